/* src/uprb_pkg.sv */
// ----------------------------------------------------------------------------
// uprb_pkg
// Shared constants, types and command codes of the receive ping-pong buffer.
// ----------------------------------------------------------------------------
package uprb_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int MAX_READ  = 64;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int PTR_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * BUF_DEPTH);
	localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_EMPTY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [BYTE_W-1:0]       data;
		logic [LEN_W-1:0]        len;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

	typedef struct packed {
		logic                    valid;
		logic [BYTE_W-1:0]       data;
		logic                    byte_valid;
		logic                    last;
	} rsp_ent_t;

endpackage

/* src/uprb_if.sv */
// ----------------------------------------------------------------------------
// uprb_req_if / uprb_rsp_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface uprb_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	logic [6:0] read_len;

	modport source (output valid, output opcode, output rx_byte, output read_len,
		input ready);
	modport sink (input valid, input opcode, input rx_byte, input read_len,
		output ready);
endinterface

interface uprb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;

	modport source (output valid, output data_byte, output byte_valid, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last,
		output ready);
endinterface

/* src/uprb_front.sv */
// ----------------------------------------------------------------------------
// uprb_front
// Accepts request items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module uprb_front import uprb_pkg::*; (
	uprb_req_if.sink    req,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic bad_len;

	// A read of length zero or longer than one buffer answers with a single marker.
	assign bad_len = (req.read_len == '0) ||
		(CMP_W'(req.read_len) > CMP_W'(BUF_DEPTH));

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		q_cmd.data = req.rx_byte;
		if (req.read_len > LEN_W'(MAX_READ)) begin
			q_cmd.len = LEN_W'(MAX_READ);
		end else begin
			q_cmd.len = req.read_len;
		end
		if (!req.opcode) begin
			q_cmd.kind = CMD_WRITE;
		end else if (bad_len) begin
			q_cmd.kind = CMD_EMPTY;
		end else begin
			q_cmd.kind = CMD_READ;
		end
	end

endmodule

/* src/uprb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// uprb_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module uprb_cmd_queue import uprb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_cmd   = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/uprb_back.sv */
// ----------------------------------------------------------------------------
// uprb_back
// Executes commands: owns the byte store, the fill and drain bookkeeping,
// the buffer flip, and a two-entry response queue fed by the store's read port.
// ----------------------------------------------------------------------------
module uprb_back import uprb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	uprb_rsp_if.source  rsp
);

	logic [BYTE_W-1:0] mem [2 * BUF_DEPTH];
	logic [BYTE_W-1:0] rd_data_s1;

	back_state_t       state_q;
	back_state_t       state_d;

	logic [CNT_W-1:0]  fill_q;
	logic              low_sel_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  drain_q;
	logic [LEN_W-1:0]  rem_q;

	logic              valid_s1;
	logic              marker_s1;
	logic              last_s1;

	rsp_ent_t          ent_q [2];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocount_q;

	logic              opop;
	logic [1:0]        used;
	logic              slot_ok;

	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              issue;
	logic              issue_marker;
	logic              issue_last;
	logic              start_read;

	logic [CNT_W-1:0]  drain_eff;
	logic [CMP_W-1:0]  n_take;
	logic              ptr_wrap;

	assign opop    = rsp.valid && rsp.ready;
	assign used    = ocount_q + {1'b0, valid_s1};
	assign slot_ok = (used < 2'd2) || opop;

	assign wr_addr = low_sel_q ? (ADDR_W'(BUF_DEPTH) + ADDR_W'(fill_q)) : ADDR_W'(fill_q);
	// The draining buffer is always the one that is not filling.
	assign rd_addr = low_sel_q ? ADDR_W'(ptr_q) : (ADDR_W'(BUF_DEPTH) + ADDR_W'(ptr_q));

	assign drain_eff = (drain_q == '0) ? fill_q : drain_q;
	assign n_take    = (CMP_W'(drain_eff) < CMP_W'(cmd.len)) ? CMP_W'(drain_eff)
		: CMP_W'(cmd.len);
	assign ptr_wrap  = (CNT_W'(ptr_q) == CNT_W'(BUF_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start_read) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (issue && issue_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop      = 1'b0;
		mem_we       = 1'b0;
		issue        = 1'b0;
		issue_marker = 1'b0;
		issue_last   = 1'b0;
		start_read   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_WRITE: begin
							cmd_pop = 1'b1;
							mem_we  = (fill_q < CNT_W'(BUF_DEPTH));
						end
						CMD_READ: begin
							if (drain_q == '0 && fill_q == '0) begin
								if (slot_ok) begin
									cmd_pop      = 1'b1;
									issue        = 1'b1;
									issue_marker = 1'b1;
									issue_last   = 1'b1;
								end
							end else begin
								cmd_pop    = 1'b1;
								start_read = 1'b1;
							end
						end
						default: begin
							if (slot_ok) begin
								cmd_pop      = 1'b1;
								issue        = 1'b1;
								issue_marker = 1'b1;
								issue_last   = 1'b1;
							end
						end
					endcase
				end
			end
			BK_READ: begin
				if (slot_ok) begin
					issue      = 1'b1;
					issue_last = (rem_q == LEN_W'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cmd.data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			fill_q    <= '0;
			low_sel_q <= 1'b0;
			ptr_q     <= '0;
			drain_q   <= '0;
			rem_q     <= '0;
			valid_s1  <= 1'b0;
			marker_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			valid_s1  <= issue;
			marker_s1 <= issue_marker;
			last_s1   <= issue_last;
			if (mem_we) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (start_read) begin
				rem_q <= LEN_W'(n_take);
				if (drain_q == '0) begin
					// Flip: the filled buffer starts draining, filling restarts.
					drain_q   <= fill_q;
					ptr_q     <= '0;
					low_sel_q <= !low_sel_q;
					fill_q    <= '0;
				end
			end
			if (issue && !issue_marker) begin
				rem_q <= rem_q - LEN_W'(1);
				if (drain_q == CNT_W'(1)) begin
					drain_q <= '0;
					ptr_q   <= '0;
				end else begin
					drain_q <= drain_q - CNT_W'(1);
					ptr_q   <= ptr_wrap ? '0 : ptr_q + PTR_W'(1);
				end
			end
		end
	end

	// Response queue; a read is issued only when a slot is sure to be free.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ent_q[owr_q].valid      <= 1'b1;
			ent_q[owr_q].data       <= marker_s1 ? '0 : rd_data_s1;
			ent_q[owr_q].byte_valid <= !marker_s1;
			ent_q[owr_q].last       <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			if (valid_s1) begin
				owr_q <= !owr_q;
			end
			if (opop) begin
				ord_q <= !ord_q;
			end
			case ({valid_s1, opop})
				2'b10:   ocount_q <= ocount_q + 2'd1;
				2'b01:   ocount_q <= ocount_q - 2'd1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

	assign rsp.valid      = (ocount_q != 2'd0) && ent_q[ord_q].valid;
	assign rsp.data_byte  = ent_q[ord_q].data;
	assign rsp.byte_valid = ent_q[ord_q].byte_valid;
	assign rsp.last       = ent_q[ord_q].last;

endmodule

/* src/uprb_top_unused_guard.sv */
// ----------------------------------------------------------------------------
// uprb_resp_check
// Not used.
// ----------------------------------------------------------------------------

/* src/uart_rx_ping_pong_buffer_unit.sv */
// ----------------------------------------------------------------------------
// uart_rx_ping_pong_buffer_unit
// Receive-side ping-pong byte buffer with a decoupled command front end.
// ----------------------------------------------------------------------------
// Request items either append a received byte to the filling buffer (dropped
// when that buffer is full) or ask for up to read_len bytes from the draining
// buffer, which swaps with the filling buffer when it runs dry. A byte arrival
// occupies the back end only while it is written. A read occupies the back end
// while it sets up and then returns one byte per cycle while the response side
// is ready. A read first passes the command queue and the set-up step; its bytes
// then pass the store's registered read port and the response queue before they
// are offered. The rate is set by the single read port of the byte store. Invalid
// reads and reads with no data answer with one empty marker. Requests queue in a
// two-entry command queue while a read drains.
module uart_rx_ping_pong_buffer_unit import uprb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	uprb_req_if.sink   req,
	uprb_rsp_if.source rsp
);

	logic q_full;
	logic q_push;
	cmd_t q_in;
	logic q_pop;
	cmd_t q_out;
	logic q_avail;

	uprb_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_in)
	);

	uprb_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_cmd   (q_out),
		.not_empty (q_avail)
	);

	uprb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_avail),
		.cmd       (q_out),
		.cmd_pop   (q_pop),
		.rsp       (rsp)
	);

endmodule

/* dv/uprb_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uprb_tb_pkg
// Request codes shared by the ping-pong buffer stimulus and its checker.
// ----------------------------------------------------------------------------
package uprb_tb_pkg;

	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_READ    = 1'b1;

endpackage

/* dv/uprb_rx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uprb_rx_checker
// Watches the request and response channels of the receive ping-pong buffer,
// keeps its own copy of both buffers and their counters, predicts the bytes
// and empty markers that every read returns, and compares each response item
// against the oldest prediction.
// ----------------------------------------------------------------------------
module uprb_rx_checker import uprb_pkg::*; import uprb_tb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	uprb_req_if  req,
	uprb_rsp_if  rsp,
	output int   fail_count,
	output int   pending_results,
	output int   bytes_out,
	output int   markers_out,
	output int   bytes_dropped,
	output int   swaps
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              byte_valid;
		logic              last;
	} drain_item_t;

	logic [BYTE_W-1:0] mirror [2*BUF_DEPTH];
	logic [CNT_W-1:0]  fill_cnt;
	logic              low_sel;
	logic [PTR_W-1:0]  drain_ptr;
	logic [CNT_W-1:0]  drain_cnt;
	drain_item_t       drain_q[$];

	task automatic push_marker();
		drain_q.push_back('{data: '0, byte_valid: 1'b0, last: 1'b1});
		markers_out++;
	endtask

	task automatic predict_request(input logic op, input logic [BYTE_W-1:0] rx_byte,
		input logic [LEN_W-1:0] read_len);
		int unsigned len;
		int unsigned n;
		int unsigned up_base;
		int unsigned off;
		len = read_len;
		if (op == OP_RX_BYTE) begin
			if (fill_cnt < BUF_DEPTH) begin
				mirror[low_sel * BUF_DEPTH + fill_cnt] = rx_byte;
				fill_cnt++;
			end else begin
				bytes_dropped++;
			end
		end else if (len == 0 || len > BUF_DEPTH) begin
			push_marker();
		end else if (drain_cnt == 0 && fill_cnt == 0) begin
			push_marker();
		end else begin
			// The filled buffer takes over draining when the current one has run dry.
			if (drain_cnt == 0) begin
				drain_cnt = fill_cnt;
				drain_ptr = '0;
				low_sel   = ~low_sel;
				fill_cnt  = '0;
				swaps++;
			end
			if (len > MAX_READ) len = MAX_READ;
			n = (drain_cnt < len) ? drain_cnt : len;
			up_base = (low_sel ? 0 : 1) * BUF_DEPTH;
			for (int unsigned i = 0; i < n; i++) begin
				off = (drain_ptr + i) % BUF_DEPTH;
				drain_q.push_back('{data: mirror[up_base + off], byte_valid: 1'b1,
					last: (i + 1 == n)});
				bytes_out++;
			end
			drain_cnt = drain_cnt - CNT_W'(n);
			if (drain_cnt == 0) drain_ptr = '0;
			else drain_ptr = PTR_W'((drain_ptr + n) % BUF_DEPTH);
		end
	endtask

	task automatic check_response();
		drain_item_t want;
		if (drain_q.size() == 0) begin
			$display("%0t ns: response item with nothing expected: data_byte=%h byte_valid=%b last=%b",
				$time, rsp.data_byte, rsp.byte_valid, rsp.last);
			fail_count++;
		end else begin
			want = drain_q.pop_front();
			if (rsp.data_byte !== want.data) begin
				$display("%0t ns: data_byte mismatch, expected %h, actual %h",
					$time, want.data, rsp.data_byte);
				fail_count++;
			end
			if (rsp.byte_valid !== want.byte_valid) begin
				$display("%0t ns: byte_valid mismatch, expected %b, actual %b",
					$time, want.byte_valid, rsp.byte_valid);
				fail_count++;
			end
			if (rsp.last !== want.last) begin
				$display("%0t ns: last mismatch, expected %b, actual %b",
					$time, want.last, rsp.last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt        = '0;
			low_sel         = 1'b0;
			drain_ptr       = '0;
			drain_cnt       = '0;
			drain_q.delete();
			fail_count      = 0;
			pending_results = 0;
			bytes_out       = 0;
			markers_out     = 0;
			bytes_dropped   = 0;
			swaps           = 0;
		end else begin
			if (req.valid && req.ready)
				predict_request(req.opcode, req.rx_byte, req.read_len);
			if (rsp.valid && rsp.ready)
				check_response();
			pending_results = drain_q.size();
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the receive ping-pong buffer: directed reads and
// byte arrivals over the empty, swap, cap and partial-drain cases, a long
// response stall, then random write bursts and reads with random idling.
// ----------------------------------------------------------------------------
module tb;
	import uprb_pkg::*;
	import uprb_tb_pkg::*;

	localparam int CLK_PERIOD_NS  = 8;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_ITEMS   = 150;
	localparam int QUIET_ITEMS    = 40;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	uprb_req_if req ();
	uprb_rsp_if rsp ();

	int fail_count;
	int pending_results;
	int bytes_out;
	int markers_out;
	int bytes_dropped;
	int swaps;

	int items_sent = 0;
	int idle_cycles = 0;
	bit send_gaps = 1'b0;
	bit rsp_gaps = 1'b0;
	bit hold_request = 1'b0;
	bit hold_active = 1'b0;

	always #(CLK_PERIOD_NS / 2) clk = ~clk;

	uart_rx_ping_pong_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	uprb_rx_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.bytes_out       (bytes_out),
		.markers_out     (markers_out),
		.bytes_dropped   (bytes_dropped),
		.swaps           (swaps)
	);

	// Offer one request item and return once it is accepted, after a random gap when send_gaps is set.
	task automatic offer(input logic op, input logic [7:0] rx_byte, input logic [6:0] read_len);
		req.opcode   <= op;
		req.rx_byte  <= rx_byte;
		req.read_len <= read_len;
		req.valid    <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_rx(input logic [7:0] rx_byte);
		offer(OP_RX_BYTE, rx_byte, 7'($urandom));
	endtask

	task automatic send_read(input logic [6:0] read_len);
		offer(OP_READ, 8'($urandom), read_len);
	endtask

	// Waiting on the clock lets the checker take in the last accepted item first.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		wait (pending_results == 0);
	endtask

	// Response side: random stall bursts, and one long hold-off on request.
	initial begin
		int hold_cnt;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				rsp.ready <= 1'b0;
				hold_active = 1'b1;
				for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clk);
				hold_request = 1'b0;
				hold_active = 1'b0;
				rsp.ready <= 1'b1;
				@(posedge clk);
			end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				rsp.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int base;
		int burst;
		req.valid    <= 1'b0;
		req.opcode   <= OP_RX_BYTE;
		req.rx_byte  <= '0;
		req.read_len <= '0;
		arst_n       <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reads, zero length, capped length, swaps and partial drains.
		send_gaps = 1'b1;
		rsp_gaps  = 1'b1;
		send_read(7'd5);
		send_read(7'd0);
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(8'hA5);
		send_rx(8'h5A);
		send_rx(8'h01);
		send_rx(8'h80);
		send_read(7'd127);
		send_read(7'd3);
		send_rx(8'h11);
		send_rx(8'h22);
		send_rx(8'h33);
		send_rx(8'h44);
		send_read(7'd1);
		send_rx(8'h55);
		send_rx(8'h66);
		send_read(7'd0);
		send_read(7'd2);
		send_read(7'd64);
		send_read(7'd64);
		send_read(7'd1);
		wait_drained();

		// Long response stall while reads keep arriving, so the request side backs up.
		send_gaps = 1'b0;
		rsp_gaps  = 1'b0;
		repeat (24) send_rx(8'($urandom));
		req.valid <= 1'b0;
		hold_request = 1'b1;
		wait (hold_active);
		repeat (4) send_read(7'd64);
		repeat (6) send_rx(8'($urandom));
		send_read(7'd64);
		wait_drained();

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS) begin
				send_gaps = 1'b0;
				rsp_gaps  = 1'b0;
			end else begin
				send_gaps = ($urandom_range(0, 3) != 0);
				rsp_gaps  = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					burst = $urandom_range(1, 24);
					repeat (burst) send_rx(8'($urandom));
					repeat ($urandom_range(1, 3)) send_read(7'($urandom_range(1, 127)));
				end
				6, 7: begin
					send_read(7'($urandom_range(0, 127)));
				end
				8: begin
					send_read(7'd0);
				end
				default: begin
					offer(1'($urandom_range(0, 1)), 8'($urandom), 7'($urandom));
				end
			endcase
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d request items; got %0d data bytes and %0d empty markers back.",
			items_sent, bytes_out, markers_out);
		$display("Buffers swapped %0d times; %0d arrivals dropped on a full buffer.",
			swaps, bytes_dropped);
		if (fail_count == 0 && pending_results == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
